### sv/kfct_pkg.sv
// Shared constants, types and a helper function of the keyed frequency counter table.
package kfct_pkg;

   localparam int ENTRIES    = 64;
   localparam int KEY_BYTES  = 8;
   localparam int COUNT_BITS = 16;

   localparam int KEY_BITS   = 8 * KEY_BYTES;
   localparam int IDX_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OUT_COUNT_BITS = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] OP_INC   = 2'd0;
   localparam logic [1:0] OP_DEC   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic STATUS_ANSWER = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic capture;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_rsp;
      logic out_busy;
   } dp_status_type;

   function automatic logic [OUT_COUNT_BITS-1:0] sat_count(input logic [COUNT_BITS-1:0] c);
      logic [32:0] wide;
      wide = 33'(c);
      if (wide > 33'h0FFFF) begin
         return {OUT_COUNT_BITS{1'b1}};
      end
      return wide[OUT_COUNT_BITS-1:0];
   endfunction

endpackage

### sv/kfct_ctrl.sv
// Controller state machine that sequences match, count read and update for one word.
module kfct_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  kfct_pkg::dp_status_type  status,
   output kfct_pkg::dp_cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       commit_ok;

   assign commit_ok = !(status.need_rsp && status.out_busy);

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.commit = commit_ok;
            if (commit_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/kfct_dpath.sv
// Datapath with the key match cells, count memory, update logic and result register.
module kfct_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  kfct_pkg::dp_cmd_type     cmd,
   output kfct_pkg::dp_status_type  status,
   input  logic [1:0]               req_tuser,
   input  logic [63:0]              req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,
   output logic [0:0]               rsp_tuser
);

   logic [kfct_pkg::KEY_BITS-1:0]   req_key;
   logic [kfct_pkg::ENTRIES-1:0]    valid_ff;
   logic [kfct_pkg::ENTRIES-1:0]    valid_in;
   logic [kfct_pkg::KEY_BITS-1:0]   keys_ff [kfct_pkg::ENTRIES];
   logic [kfct_pkg::COUNT_BITS-1:0] cnt_mem_ff [kfct_pkg::ENTRIES];
   logic [kfct_pkg::ENTRIES-1:0]    match;
   logic [kfct_pkg::IDX_BITS-1:0]   hit_idx;
   logic                            free_found;
   logic [kfct_pkg::IDX_BITS-1:0]   free_idx;

   logic [1:0]                      op_ff;
   logic [kfct_pkg::KEY_BITS-1:0]   key_ff;
   logic                            hit_ff;
   logic [kfct_pkg::IDX_BITS-1:0]   hit_idx_ff;
   logic                            free_ff;
   logic [kfct_pkg::IDX_BITS-1:0]   free_idx_ff;
   logic [kfct_pkg::COUNT_BITS-1:0] cnt_rd_ff;

   logic                            wr_en;
   logic [kfct_pkg::IDX_BITS-1:0]   wr_addr;
   logic [kfct_pkg::COUNT_BITS-1:0] wr_data;
   logic [kfct_pkg::COUNT_BITS-1:0] dec_value;
   logic                            key_wr;
   logic                            set_valid;
   logic                            clr_valid;
   logic                            need_rsp;
   logic [15:0]                     rsp_count;
   logic                            rsp_status;

   logic                            rsp_valid_ff;
   logic [15:0]                     rsp_count_ff;
   logic                            rsp_status_ff;

   assign req_key = req_tdata[kfct_pkg::KEY_BITS-1:0];

   always_comb begin
      for (int i = 0; i < kfct_pkg::ENTRIES; i++) begin
         match[i] = valid_ff[i] && (keys_ff[i] == req_key);
      end
   end

   // A key sits in at most one entry, so the hit index is an OR of the matching indexes.
   always_comb begin
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = 0; i < kfct_pkg::ENTRIES; i++) begin
         if (match[i]) begin
            hit_idx = hit_idx | kfct_pkg::IDX_BITS'(i);
         end
      end
      for (int i = kfct_pkg::ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = kfct_pkg::IDX_BITS'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser;
         key_ff      <= req_key;
         hit_ff      <= |match;
         hit_idx_ff  <= hit_idx;
         free_ff     <= free_found;
         free_idx_ff <= free_idx;
      end
   end

   assign dec_value = (cnt_rd_ff != '0) ? cnt_rd_ff - 1'b1 : '0;

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_data    = cnt_rd_ff;
      key_wr     = 1'b0;
      set_valid  = 1'b0;
      clr_valid  = 1'b0;
      need_rsp   = 1'b0;
      rsp_count  = '0;
      rsp_status = kfct_pkg::STATUS_ANSWER;
      unique case (op_ff)
         kfct_pkg::OP_INC: begin
            if (hit_ff) begin
               wr_en   = 1'b1;
               wr_data = (cnt_rd_ff == kfct_pkg::COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
            end else if (free_ff) begin
               wr_en     = 1'b1;
               wr_addr   = free_idx_ff;
               wr_data   = kfct_pkg::COUNT_BITS'(1);
               key_wr    = 1'b1;
               set_valid = 1'b1;
            end else begin
               need_rsp   = 1'b1;
               rsp_status = kfct_pkg::STATUS_FULL;
            end
         end
         kfct_pkg::OP_DEC: begin
            if (hit_ff) begin
               wr_en     = 1'b1;
               wr_data   = dec_value;
               clr_valid = (dec_value == '0);
            end
         end
         kfct_pkg::OP_QUERY: begin
            need_rsp  = 1'b1;
            rsp_count = kfct_pkg::sat_count(hit_ff ? cnt_rd_ff : '0);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && set_valid) begin
         valid_in[free_idx_ff] = 1'b1;
      end
      if (cmd.commit && clr_valid) begin
         valid_in[hit_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && key_wr) begin
         keys_ff[free_idx_ff] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         cnt_mem_ff[wr_addr] <= wr_data;
      end
      cnt_rd_ff <= cnt_mem_ff[hit_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && need_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && need_rsp) begin
         rsp_count_ff  <= rsp_count;
         rsp_status_ff <= rsp_status;
      end
   end

   assign status.need_rsp = need_rsp;
   assign status.out_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_count_ff;
   assign rsp_tuser[0] = rsp_status_ff;

endmodule

### sv/keyed_frequency_counter_table_top.sv
// Top level of the keyed frequency counter table: controller and datapath.
// A word is taken in the idle cycle, where its key is matched against all entries at once.
// The read state then reads the count memory and the write state applies the update and
// registers any result word for rsp; no new word is taken until that update is done.
// A result waiting on a stalled rsp side holds the update cycle until the slot frees.
// Synchronous reset clears all entry valid bits and the control state; no clearing pass.
module keyed_frequency_counter_table_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[63:0]
   input  logic [1:0]  req_tuser,   // opcode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // count[15:0]
   output logic [0:0]  rsp_tuser    // status[0]
);

   kfct_pkg::dp_cmd_type    cmd;
   kfct_pkg::dp_status_type status;

   kfct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kfct_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sv/kfct_checker.sv
// Port-level checker for the keyed frequency counter table and its bind statement.
module kfct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result word changed or dropped.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("Input taken again before the update of the previous word.");

   a_no_fast_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("Result word appeared one cycle after acceptance.");

   a_full_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[0] == kfct_pkg::STATUS_FULL) |-> rsp_tdata == 16'd0)
      else $error("Dropped increment reported with a nonzero count.");

endmodule

bind keyed_frequency_counter_table_top kfct_checker u_kfct_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### test/keyed_frequency_counter_table_top_tb.sv
// Self-checking testbench for the keyed frequency counter table with a stream driver and monitor.
module keyed_frequency_counter_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]  OP_IGNORED = 2'd3;
   localparam logic [63:0] KEY_MASK   = {64{1'b1}} >> (64 - kfct_pkg::KEY_BITS);
   localparam int          QUIET_LIMIT = 4000;
   localparam int          CALM_TAIL   = 150;
   localparam int          POOL_SIZE   = 96;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] key;
   } tally_cmd_type;

   typedef struct packed {
      logic [15:0] count;
      logic        status;
   } tally_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // key[63:0]
   logic [1:0]  req_tuser = kfct_pkg::OP_INC;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;   // count[15:0]
   logic [0:0]  rsp_tuser;   // status[0]

   tally_cmd_type    pending_cmds[$];
   tally_answer_type expected_answers[$];

   logic [63:0]                     tally_key[kfct_pkg::ENTRIES];
   logic [kfct_pkg::COUNT_BITS-1:0] tally_cnt[kfct_pkg::ENTRIES];
   logic                            tally_used[kfct_pkg::ENTRIES];

   logic [63:0] key_pool[POOL_SIZE];

   int errors = 0;
   int accepted = 0;
   int n_inc = 0, n_dec = 0, n_query = 0, n_ignored = 0;
   int n_answers = 0, n_full = 0;
   int gap_left = 0, stall_left = 0, quiet = 0;

   keyed_frequency_counter_table_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int find_key(input logic [63:0] k);
      for (int i = 0; i < kfct_pkg::ENTRIES; i++) begin
         if (tally_used[i] && tally_key[i] == k) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic int find_free_slot();
      for (int i = 0; i < kfct_pkg::ENTRIES; i++) begin
         if (!tally_used[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Idling pauses in every fourth window of words and stops near the end of the run.
   function automatic bit idling_allowed();
      return pending_cmds.size() > CALM_TAIL && ((accepted / 120) % 4) != 3;
   endfunction

   task automatic update_tally(input logic [1:0] op, input logic [63:0] raw_key);
      logic [63:0]      k;
      int               hit;
      int               slot;
      tally_answer_type ans;
      k = raw_key & KEY_MASK;
      hit = find_key(k);
      case (op)
         kfct_pkg::OP_INC: begin
            n_inc++;
            if (hit >= 0) begin
               if (tally_cnt[hit] != kfct_pkg::COUNT_MAX) begin
                  tally_cnt[hit] = tally_cnt[hit] + 1'b1;
               end
            end else begin
               slot = find_free_slot();
               if (slot < 0) begin
                  ans.count = '0;
                  ans.status = kfct_pkg::STATUS_FULL;
                  expected_answers.push_back(ans);
                  n_full++;
               end else begin
                  tally_used[slot] = 1'b1;
                  tally_key[slot] = k;
                  tally_cnt[slot] = kfct_pkg::COUNT_BITS'(1);
               end
            end
         end
         kfct_pkg::OP_DEC: begin
            n_dec++;
            if (hit >= 0) begin
               if (tally_cnt[hit] != '0) begin
                  tally_cnt[hit] = tally_cnt[hit] - 1'b1;
               end
               if (tally_cnt[hit] == '0) begin
                  tally_used[hit] = 1'b0;
               end
            end
         end
         kfct_pkg::OP_QUERY: begin
            n_query++;
            ans.count = '0;
            if (hit >= 0) begin
               ans.count = (32'(tally_cnt[hit]) > 32'hFFFF) ? 16'hFFFF : 16'(tally_cnt[hit]);
            end
            ans.status = kfct_pkg::STATUS_ANSWER;
            expected_answers.push_back(ans);
         end
         default: begin
            n_ignored++;
         end
      endcase
   endtask

   task automatic add_cmd(input logic [1:0] op, input logic [63:0] k);
      tally_cmd_type c;
      c.opcode = op;
      c.key = k;
      pending_cmds.push_back(c);
   endtask

   function automatic logic [63:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Request driver: holds a word until accepted, with random bursts of gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (req_tvalid) begin
            update_tally(req_tuser, req_tdata);
            accepted++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0 && idling_allowed()
                      && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 10);
            req_tvalid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_cmds[0].key;
            req_tuser <= pending_cmds[0].opcode;
            void'(pending_cmds.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: checks each result word and stalls the result side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_answers++;
            if (expected_answers.size() == 0) begin
               $error("unexpected result word: count %0d status %0d", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               if (rsp_tdata !== expected_answers[0].count) begin
                  $error("count mismatch: expected %0d, actual %0d",
                         expected_answers[0].count, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser[0] !== expected_answers[0].status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         expected_answers[0].status, rsp_tuser[0]);
                  errors++;
               end
               void'(expected_answers.pop_front());
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] word_key;
      logic [63:0] sat_key;
      int          nbytes;
      int          mode;
      int          pick;
      logic [1:0]  op;

      for (int i = 0; i < kfct_pkg::ENTRIES; i++) begin
         tally_used[i] = 1'b0;
         tally_key[i] = '0;
         tally_cnt[i] = '0;
      end

      // Directed: extremes of the key, every opcode, absent keys and the ignored opcode.
      add_cmd(kfct_pkg::OP_QUERY, 64'd0);
      add_cmd(kfct_pkg::OP_INC, 64'd0);
      add_cmd(kfct_pkg::OP_QUERY, 64'd0);
      add_cmd(kfct_pkg::OP_INC, {64{1'b1}});
      add_cmd(kfct_pkg::OP_INC, {64{1'b1}});
      add_cmd(kfct_pkg::OP_QUERY, {64{1'b1}});
      add_cmd(kfct_pkg::OP_DEC, 64'h5555_AAAA_5555_AAAA);
      add_cmd(kfct_pkg::OP_DEC, 64'd0);
      add_cmd(kfct_pkg::OP_QUERY, 64'd0);
      add_cmd(OP_IGNORED, {64{1'b1}});
      add_cmd(OP_IGNORED, 64'd7);
      add_cmd(kfct_pkg::OP_QUERY, {64{1'b1}});
      add_cmd(kfct_pkg::OP_QUERY, 64'd7);
      add_cmd(kfct_pkg::OP_INC, {32'd0, "e", "f", "a", "c"});
      add_cmd(kfct_pkg::OP_INC, {56'd0, "a"});
      add_cmd(kfct_pkg::OP_QUERY, {32'd0, "e", "f", "a", "c"});
      add_cmd(kfct_pkg::OP_QUERY, {56'd0, "a"});
      add_cmd(kfct_pkg::OP_QUERY, 64'h8000_0000_0000_0000);

      // Fill the table past capacity, probe it while full, then empty those entries again.
      for (int i = 0; i <= kfct_pkg::ENTRIES; i++) begin
         add_cmd(kfct_pkg::OP_INC, 64'h1000 + i);
      end
      add_cmd(kfct_pkg::OP_INC, 64'hDEAD_0000_0000_0001);
      add_cmd(kfct_pkg::OP_QUERY, 64'hDEAD_0000_0000_0001);
      add_cmd(kfct_pkg::OP_QUERY, 64'h1000);
      for (int i = 0; i <= kfct_pkg::ENTRIES; i++) begin
         add_cmd(kfct_pkg::OP_DEC, 64'h1000 + i);
      end
      add_cmd(kfct_pkg::OP_QUERY, 64'h1000);

      // Build up one count, then step it back down by one.
      sat_key = {40'd0, "e", "e", "f"};
      for (int i = 0; i < 12; i++) begin
         add_cmd(kfct_pkg::OP_INC, sat_key);
      end
      add_cmd(kfct_pkg::OP_QUERY, sat_key);
      add_cmd(kfct_pkg::OP_DEC, sat_key);
      add_cmd(kfct_pkg::OP_QUERY, sat_key);

      for (int i = 0; i < POOL_SIZE; i++) begin
         if (i % 2 == 0) begin
            key_pool[i] = random_key();
         end else begin
            nbytes = $urandom_range(1, kfct_pkg::KEY_BYTES);
            word_key = '0;
            for (int b = 0; b < nbytes; b++) begin
               word_key[8*b +: 8] = 8'($urandom_range(8'h61, 8'h7A));
            end
            key_pool[i] = word_key;
         end
      end

      // Random part in windows that lean toward filling, draining or mixed traffic.
      for (int n = 0; n < 1783; n++) begin
         mode = (n / 150) % 3;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            op = OP_IGNORED;
         end else if (pick < 20) begin
            op = kfct_pkg::OP_QUERY;
         end else if (mode == 0) begin
            op = (pick < 80) ? kfct_pkg::OP_INC : kfct_pkg::OP_DEC;
         end else if (mode == 1) begin
            op = (pick < 40) ? kfct_pkg::OP_INC : kfct_pkg::OP_DEC;
         end else begin
            op = (pick < 60) ? kfct_pkg::OP_INC : kfct_pkg::OP_DEC;
         end
         if ($urandom_range(0, 9) == 0) begin
            add_cmd(op, random_key());
         end else begin
            add_cmd(op, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid || expected_answers.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);

      $display("Covered %0d words: %0d increments, %0d decrements, %0d queries, %0d ignored.",
               accepted, n_inc, n_dec, n_query, n_ignored);
      $display("Checked %0d result words, %0d of them table-full drops.", n_answers, n_full);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
